// ===== hw/rtl/hotp_pkg.sv =====
// Shared types, constants and SHA-1 helpers for the HOTP code generator.
package hotp_pkg;
  localparam int unsigned KeyW = 160;
  localparam int unsigned CtrW = 64;
  localparam int unsigned CodeW = 27;
  localparam int unsigned TruncW = 31;
  localparam int unsigned DigW = 4;

  localparam logic [1:0] RegKeyUpper = 2'd0;
  localparam logic [1:0] RegKeyMiddle = 2'd1;
  localparam logic [1:0] RegKeyLower = 2'd2;
  localparam logic [1:0] RegDigits = 2'd3;

  localparam logic [159:0] ShaInit =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
  localparam logic [7:0] Ipad = 8'h36;
  localparam logic [7:0] Opad = 8'h5c;

  // one queued job: counter plus the key and modulus it was accepted under
  typedef struct packed {
    logic [CtrW-1:0] ctr;
    logic [KeyW-1:0] key;
    logic [26:0] modulus;
  } job_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20) round_k = 32'h5A827999;
    else if (r < 7'd40) round_k = 32'h6ED9EBA1;
    else if (r < 7'd60) round_k = 32'h8F1BBCDC;
    else round_k = 32'hCA62C1D6;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20) round_f = (b & c) | (~b & d);
    else if (r < 7'd40 || r >= 7'd60) round_f = b ^ c ^ d;
    else round_f = (b & c) | (b & d) | (c & d);
  endfunction
endpackage

// ===== hw/rtl/hotp_code_generator.sv =====
// Top level of the HOTP code generator.
// Each job runs through the queue, then 4 SHA-1 blocks (load, 80 rounds, add),
// truncate and a 12-step modulo on the single shared round unit, which finishes
// one code before it takes the next job; a two-beat queue takes new counters
// back to back while it has room.
// Reset: synchronous; key clears to zero, digit count to six, queue empties.
module hotp_code_generator (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [63:0] moving_counter,
  output logic out_valid,
  input  logic out_ready,
  output logic [26:0] otp_code,
  output logic [30:0] truncated_value
);
  logic job_valid, job_ready;
  hotp_pkg::job_t job;

  hotp_front u_front (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
    .moving_counter, .job_valid, .job_ready, .job);
  hotp_back u_back (.clk, .rst, .job_valid, .job_ready, .job, .out_valid, .out_ready,
    .otp_code, .truncated_value);

  a_code_below_mod: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> otp_code < 27'd100000000) else $error("code out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(otp_code)) else $error("result dropped");
endmodule

// ===== hw/rtl/hotp_front.sv =====
// Front end: holds configuration and turns accepted counters into jobs.
module hotp_front (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [63:0] moving_counter,
  output logic job_valid,
  input  logic job_ready,
  output hotp_pkg::job_t job
);
  logic [63:0] key_upper, key_middle;
  logic [31:0] key_lower;
  logic [3:0] digit_count;
  logic [26:0] modulus;
  logic [1:0] cnt;
  hotp_pkg::job_t q [2];
  logic rd, wr;

  always_comb begin
    if (digit_count <= 4'd6) modulus = 27'd1000000;
    else if (digit_count == 4'd7) modulus = 27'd10000000;
    else modulus = 27'd100000000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_middle <= '0;
      key_lower <= '0;
      digit_count <= 4'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        hotp_pkg::RegKeyUpper: key_upper <= cfg_data;
        hotp_pkg::RegKeyMiddle: key_middle <= cfg_data;
        hotp_pkg::RegKeyLower: key_lower <= cfg_data[31:0];
        hotp_pkg::RegDigits: digit_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign in_ready = cnt != 2'd2;
  assign job_valid = cnt != 2'd0;
  assign job = q[0];
  assign wr = in_valid && in_ready;
  assign rd = job_valid && job_ready;

  // two-entry queue; entry 0 is the head
  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    if (wr && (cnt == 2'd0 || (cnt == 2'd1 && rd)))
      q[0] <= '{moving_counter, {key_upper, key_middle, key_lower}, modulus};
    else if (rd) q[0] <= q[1];
    if (wr && cnt == 2'd1 && !rd)
      q[1] <= '{moving_counter, {key_upper, key_middle, key_lower}, modulus};
  end
endmodule

// ===== hw/rtl/hotp_back.sv =====
// Back end: four SHA-1 compressions, truncation and iterative modulo.
module hotp_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  hotp_pkg::job_t job,
  output logic out_valid,
  input  logic out_ready,
  output logic [26:0] otp_code,
  output logic [30:0] truncated_value
);
  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ROUND, S_ADD, S_TRUNC, S_MOD, S_DONE} state_t;
  state_t state;
  logic [1:0] blk;
  logic [6:0] rnd;
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [159:0] h, ihash, ichain, ochain;
  hotp_pkg::job_t cur;
  logic [511:0] block;
  logic [31:0] wn, wr_cur, t;
  logic [159:0] hsum;
  logic [3:0] off;
  logic [31:0] trunc;
  logic [3:0] mbit;
  logic [37:0] dsh;
  logic [31:0] rem;
  logic [31:0] wkey [5];

  always_comb begin
    for (int i = 0; i < 5; i++) wkey[i] = cur.key[159-32*i -: 32];
  end

  always_comb begin
    block = '0;
    case (blk)
      2'd0: block = {cur.key ^ {20{hotp_pkg::Ipad}}, {44{hotp_pkg::Ipad}}};
      2'd1: block = {cur.ctr, 8'h80, 376'd0, 64'd576};
      2'd2: block = {cur.key ^ {20{hotp_pkg::Opad}}, {44{hotp_pkg::Opad}}};
      2'd3: block = {ihash, 8'h80, 280'd0, 64'd672};
      default: block = '0;
    endcase
  end

  assign wr_cur = (rnd < 7'd16) ? w[rnd[3:0]] : wn;
  assign wn = {w[13] ^ w[8] ^ w[2] ^ w[0]} << 1 | (w[13] ^ w[8] ^ w[2] ^ w[0]) >> 31;
  assign t = {a[26:0], a[31:27]} + hotp_pkg::round_f(rnd, b, c, d) + e +
             hotp_pkg::round_k(rnd) + wr_cur;
  assign hsum = {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  assign job_ready = state == S_IDLE;
  assign out_valid = state == S_DONE;
  assign off = h[3:0];

  always_comb begin
    trunc = h[159 - 8*off -: 32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (job_valid) begin
          cur <= job;
          blk <= 2'd0;
          h <= hotp_pkg::ShaInit;
          state <= S_LOAD;
        end
        S_LOAD: begin
          for (int i = 0; i < 16; i++) w[i] <= block[511-32*i -: 32];
          {a, b, c, d, e} <= h;
          rnd <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          // advance the schedule window only once it runs past the block words
          if (rnd >= 7'd16) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15] <= wn;
          end
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= S_ADD;
        end
        S_ADD: begin
          case (blk)
            2'd0: begin ichain <= hsum; h <= hsum; end
            2'd1: begin ihash <= hsum; h <= hotp_pkg::ShaInit; end
            2'd2: begin ochain <= hsum; h <= hsum; end
            default: h <= hsum;
          endcase
          blk <= blk + 2'd1;
          state <= (blk == 2'd3) ? S_TRUNC : S_LOAD;
        end
        S_TRUNC: begin
          truncated_value <= trunc[30:0];
          rem <= {1'b0, trunc[30:0]};
          // quotient stays below 2^12 for a modulus of at least a million
          dsh <= {cur.modulus, 11'd0};
          mbit <= 4'd11;
          state <= S_MOD;
        end
        S_MOD: begin
          // restoring reduction, one shift of the modulus per cycle
          if ({6'd0, rem} >= dsh) rem <= rem - dsh[31:0];
          dsh <= dsh >> 1;
          mbit <= mbit - 4'd1;
          if (mbit == 4'd0) state <= S_DONE;
        end
        S_DONE: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign otp_code = rem[26:0];
  logic unused;
  assign unused = ^{ichain, ochain, wkey[0], wkey[1], wkey[2], wkey[3], wkey[4], trunc[31]};
endmodule

// ===== dv/hotp_code_generator_tb.sv =====
// Testbench for the HOTP code generator: directed and random counters checked against a SHA-1 HMAC predictor.
module hotp_code_generator_tb;
  typedef struct {
    logic [26:0] code;
    logic [30:0] trunc;
  } otp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = hotp_pkg::RegKeyUpper;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [63:0] moving_counter = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [26:0] otp_code;
  logic [30:0] truncated_value;

  logic [159:0] key_shadow = '0;
  logic [3:0] digits_shadow = 4'd6;
  logic [63:0] counter_queue[$];
  otp_t expected_codes[$];
  int unsigned errors = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  logic driver_hold = 1'b0;

  hotp_code_generator dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [159:0] sha1_compress(input logic [159:0] h, input logic [511:0] blk);
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    {a, b, c, d, e} = h;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  endfunction

  function automatic otp_t hotp_predict(input logic [159:0] key, input logic [3:0] digits,
                                        input logic [63:0] ctr);
    logic [511:0] ipad_blk, opad_blk;
    logic [159:0] inner, digest;
    logic [7:0] dbyte[20];
    logic [31:0] tv, modulus;
    int unsigned off, nd;
    otp_t r;
    ipad_blk = {key, 352'd0} ^ {64{hotp_pkg::Ipad}};
    opad_blk = {key, 352'd0} ^ {64{hotp_pkg::Opad}};
    // 72-byte message: key block, then counter, pad and length 576
    inner = sha1_compress(sha1_compress(hotp_pkg::ShaInit, ipad_blk),
                          {ctr, 8'h80, 376'd0, 64'd576});
    // 84-byte message: length 672
    digest = sha1_compress(sha1_compress(hotp_pkg::ShaInit, opad_blk),
                           {inner, 8'h80, 280'd0, 64'd672});
    for (int i = 0; i < 20; i++) dbyte[i] = digest[159 - 8*i -: 8];
    off = dbyte[19] & 8'h0f;
    tv = {1'b0, dbyte[off][6:0], dbyte[off+1], dbyte[off+2], dbyte[off+3]};
    nd = digits < 6 ? 6 : (digits > 8 ? 8 : digits);
    modulus = 1;
    for (int i = 0; i < nd; i++) modulus = modulus * 10;
    r.code = 27'(tv % modulus);
    r.trunc = tv[30:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // driver: predict at acceptance with the settings in force then
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_codes.push_back(hotp_predict(key_shadow, digits_shadow, moving_counter));
        send_gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
        // follow with the next beat at once when no gap is drawn
        if (send_gap == 0 && !driver_hold && counter_queue.size() > 0) begin
          moving_counter <= counter_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) send_gap--;
        else if (!driver_hold && counter_queue.size() > 0) begin
          moving_counter <= counter_queue.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          report("unexpected beat", 64'(otp_code), 64'd0);
        end else begin
          otp_t e;
          e = expected_codes.pop_front();
          if (otp_code !== e.code) report("otp_code", 64'(otp_code), 64'(e.code));
          if (truncated_value !== e.trunc)
            report("truncated_value", 64'(truncated_value), 64'(e.trunc));
        end
        recv_gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      hotp_pkg::RegKeyUpper: key_shadow[159:96] = val;
      hotp_pkg::RegKeyMiddle: key_shadow[95:32] = val;
      hotp_pkg::RegKeyLower: key_shadow[31:0] = val[31:0];
      hotp_pkg::RegDigits: digits_shadow = val[3:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (counter_queue.size() == 0 && !in_valid && expected_codes.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_key(input logic [63:0] fill);
    write_reg(hotp_pkg::RegKeyUpper, fill == 1 ? {$urandom, $urandom} : fill);
    write_reg(hotp_pkg::RegKeyMiddle, fill == 1 ? {$urandom, $urandom} : fill);
    write_reg(hotp_pkg::RegKeyLower, fill == 1 ? {$urandom, $urandom} : fill);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: counter_queue.push_back(64'($urandom_range(0, 1000)));
        1: counter_queue.push_back(~64'($urandom_range(0, 1000)));
        default: counter_queue.push_back({$urandom, $urandom});
      endcase
    end
  endtask

  initial begin
    logic [3:0] digit_set[6];
    digit_set = '{4'd6, 4'd8, 4'd0, 4'd15, 4'd7, 4'd5};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // reset key, digit count six; RFC-style counters and extremes
    for (int i = 0; i < 10; i++) counter_queue.push_back(64'(i));
    counter_queue.push_back('1);
    counter_queue.push_back(64'h8000_0000_0000_0000);
    counter_queue.push_back(64'h5555_5555_5555_5555);
    drain();
    // RFC 4226 test key "12345678901234567890"
    write_reg(hotp_pkg::RegKeyUpper, 64'h3132333435363738);
    write_reg(hotp_pkg::RegKeyMiddle, 64'h3930313233343536);
    write_reg(hotp_pkg::RegKeyLower, 64'hFFFF_FFFF_3738_3930);
    for (int i = 0; i < 10; i++) counter_queue.push_back(64'(i));
    drain();
    for (int p = 0; p < 6; p++) begin
      write_reg(hotp_pkg::RegDigits, {60'd0, digit_set[p]});
      if (p == 1) random_key('1);
      else if (p == 2) random_key('0);
      else random_key(1);
      add_random(p == 3 ? 150 : 275);
      if (p == 3) begin
        // hold the sender until every code is back
        wait (counter_queue.size() == 0 && !in_valid);
        driver_hold = 1'b1;
        wait (expected_codes.size() == 0);
        driver_hold = 1'b0;
        add_random(150);
      end
      drain();
    end
    repeat (400) @(posedge clk);
    if (errors == 0) $display("hotp_code_generator_tb: PASS");
    else $display("hotp_code_generator_tb: FAIL");
    $finish;
  end

  initial begin
    #40000000;
    $display("hotp_code_generator_tb: FAIL");
    $finish;
  end
endmodule
